### rtl/core/link_change_blink_indicator_assert.svh
// Assertion helpers for the link-change blink indicator.
// The active-high clock edge and active-low reset are those of the including module.
`ifndef LINK_CHANGE_BLINK_INDICATOR_ASSERT_SVH
`define LINK_CHANGE_BLINK_INDICATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define LCBI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcbi assertion failed");

// Next-cycle implication
`define LCBI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcbi assertion failed");

`else

`define LCBI_ASSERT_NOW(label, ante, cons)
`define LCBI_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/core/lcbi_pkg.sv
package lcbi_pkg;

  localparam int PORTS  = 6;
  localparam int CONN_W = 6;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int CNT_W  = 4;
  localparam int REM_W  = CNT_W + 1;
  localparam int IDX_W  = 3;

  localparam logic OP_POLL = 1'b0;
  localparam logic OP_MSG  = 1'b1;

  localparam logic [7:0] MSG_BLINK_REQUEST = 8'd1;

  localparam logic [7:0] COLOR_WHITE = 8'd0;
  localparam logic [7:0] COLOR_RED   = 8'd1;
  localparam logic [7:0] COLOR_GREEN = 8'd2;

  localparam logic [IDX_W-1:0] REG_POLL_PERIOD  = 3'd0;
  localparam logic [IDX_W-1:0] REG_STARTUP      = 3'd1;
  localparam logic [IDX_W-1:0] REG_HALF_PERIOD  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SETTLE       = 3'd3;
  localparam logic [IDX_W-1:0] REG_BLINK_COUNT  = 3'd4;

  localparam logic [CFG_W-1:0] RST_POLL_PERIOD = 16'd400;
  localparam logic [CFG_W-1:0] RST_STARTUP     = 16'd1000;
  localparam logic [CFG_W-1:0] RST_HALF_PERIOD = 16'd200;
  localparam logic [CFG_W-1:0] RST_SETTLE      = 16'd500;
  localparam logic [CNT_W-1:0] RST_BLINK_COUNT = 4'd3;

  typedef struct packed {
    logic             led_write;
    logic [1:0]       lamp_color;
    logic [CONN_W-1:0] send_mask;
    logic [7:0]       send_color;
  } res_t;

  typedef struct packed {
    logic             found;
    logic [PORTS-1:0] grant;
    logic [7:0]       color;
  } pick_t;

  // Wrapping time order: a lies strictly after b within half the range.
  function automatic logic is_after(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

  function automatic logic [1:0] shown(input logic [7:0] color);
    return (color <= COLOR_GREEN) ? color[1:0] : COLOR_WHITE[1:0];
  endfunction

endpackage

### rtl/core/lcbi_port_lane.sv
module lcbi_port_lane
  import lcbi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              cur,
  input  logic [CFG_W-1:0]  settle_time,
  input  logic              upd,
  output logic              cand
);

  logic              state_r;
  logic [TIME_W-1:0] last_change_r;
  logic [TIME_W-1:0] settle_end;

  assign settle_end = last_change_r + {{(TIME_W-CFG_W){1'b0}}, settle_time};
  assign cand = (state_r != cur) && is_after(now_ms, settle_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= 1'b0;
      last_change_r <= '0;
    end else if (upd) begin
      state_r       <= cur;
      last_change_r <= now_ms;
    end
  end

endmodule

### rtl/core/lcbi_merge.sv
module lcbi_merge
  import lcbi_pkg::*;
(
  input  logic [PORTS-1:0] cand,
  input  logic [PORTS-1:0] cur,
  output pick_t            pick
);

  // Lowest-numbered candidate wins.
  always_comb begin
    pick = '0;
    for (int p = PORTS - 1; p >= 0; p--) begin
      if (cand[p]) begin
        pick.found = 1'b1;
        pick.grant = '0;
        pick.grant[p] = 1'b1;
        pick.color = cur[p] ? COLOR_GREEN : COLOR_RED;
      end
    end
  end

endmodule

### rtl/core/link_change_blink_indicator.sv
// Channel  | Handshake           | Payload
// in_      | in_valid/in_ready   | operation, now_ms, connected_ports, msg_type, msg_color
// out_     | out_valid/out_ready | led_write, lamp_color, send_mask, send_color
// cfg_     | cfg_we (no wait)    | cfg_index, cfg_wdata
//
// One transaction per cycle while in_ready is high: each item is decided in the cycle it is accepted,
// using the six port lanes and the priority merge, and its result is registered.
// An output register plus one skid entry let in_ready stay high when the output stalls;
// in_ready drops only while the skid entry is full.
// Synchronous active-low reset loads the register defaults and clears the blink and port
// state; no clearing pass is needed.
module link_change_blink_indicator
  import lcbi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [TIME_W-1:0] in_now_ms,
  input  logic [CONN_W-1:0] in_connected_ports,
  input  logic [7:0]        in_msg_type,
  input  logic [7:0]        in_msg_color,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_led_write,
  output logic [1:0]        out_lamp_color,
  output logic [CONN_W-1:0] out_send_mask,
  output logic [7:0]        out_send_color,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

`include "link_change_blink_indicator_assert.svh"

  logic [CFG_W-1:0]  poll_period_r;
  logic [CFG_W-1:0]  half_period_r;
  logic [CFG_W-1:0]  settle_r;
  logic [CNT_W-1:0]  blink_count_r;

  logic [TIME_W-1:0] next_poll_r, next_poll_nxt;
  logic [TIME_W-1:0] deadline_r, deadline_nxt;
  logic [REM_W-1:0]  remaining_r, remaining_nxt;
  logic [7:0]        held_r, held_nxt;
  logic              active_r, active_nxt;

  logic              out_valid_r, skid_valid_r;
  res_t              out_r, skid_r;
  res_t              res;

  logic              acc;
  logic              out_take;
  logic              poll_ok;
  logic              blink_adv;
  logic              port_go;
  logic              msg_go;
  logic              start;
  logic [7:0]        start_color;
  logic [7:0]        adv_color;
  logic [REM_W-1:0]  rem_dec;
  logic [PORTS-1:0]  cur;
  logic [PORTS-1:0]  cand;
  pick_t             pick;

  assign in_ready = !skid_valid_r;
  assign acc      = in_valid && in_ready;
  assign out_take = out_valid_r && out_ready;

  // Ports past the mask width read as disconnected.
  for (genvar p = 0; p < PORTS; p++) begin : g_lane
    if (p < CONN_W) begin : g_cur
      assign cur[p] = in_connected_ports[p];
    end else begin : g_off
      assign cur[p] = 1'b0;
    end

    lcbi_port_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .now_ms      (in_now_ms),
      .cur         (cur[p]),
      .settle_time (settle_r),
      .upd         (acc && port_go && pick.grant[p]),
      .cand        (cand[p])
    );
  end

  lcbi_merge u_merge (
    .cand (cand),
    .cur  (cur),
    .pick (pick)
  );

  assign poll_ok   = (in_operation == OP_POLL) && is_after(in_now_ms, next_poll_r);
  assign blink_adv = poll_ok && (remaining_r != '0) && is_after(in_now_ms, deadline_r);
  assign port_go   = poll_ok && !blink_adv && pick.found;
  assign msg_go    = (in_operation == OP_MSG) && (in_msg_type == MSG_BLINK_REQUEST) && !active_r;
  assign start     = port_go || msg_go;
  assign start_color = msg_go ? in_msg_color : pick.color;
  assign rem_dec   = remaining_r - 1'b1;
  assign adv_color = (rem_dec == '0 || !remaining_r[0]) ? COLOR_WHITE : held_r;

  always_comb begin
    res = '0;
    if (blink_adv) begin
      res.led_write  = 1'b1;
      res.lamp_color = shown(adv_color);
    end else if (start) begin
      res.led_write  = 1'b1;
      res.lamp_color = shown(start_color);
      res.send_mask  = in_connected_ports;
      res.send_color = start_color;
    end
  end

  always_comb begin
    next_poll_nxt = next_poll_r;
    deadline_nxt  = deadline_r;
    remaining_nxt = remaining_r;
    held_nxt      = held_r;
    active_nxt    = active_r;
    if (acc) begin
      if (poll_ok) begin
        next_poll_nxt = in_now_ms + {{(TIME_W-CFG_W){1'b0}}, poll_period_r};
      end
      if (blink_adv || start) begin
        deadline_nxt = in_now_ms + {{(TIME_W-CFG_W){1'b0}}, half_period_r};
      end
      if (blink_adv) begin
        remaining_nxt = rem_dec;
        if (rem_dec == '0) begin
          active_nxt = 1'b0;
        end
      end else if (start) begin
        remaining_nxt = {blink_count_r, 1'b0};
        held_nxt      = start_color;
        active_nxt    = 1'b1;
      end
    end
    // Startup delay write reloads the poll deadline.
    if (cfg_we && cfg_index == REG_STARTUP) begin
      next_poll_nxt = {{(TIME_W-CFG_W){1'b0}}, cfg_wdata};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_poll_r <= {{(TIME_W-CFG_W){1'b0}}, RST_STARTUP};
      deadline_r  <= '0;
      remaining_r <= '0;
      held_r      <= '0;
      active_r    <= 1'b0;
    end else begin
      next_poll_r <= next_poll_nxt;
      deadline_r  <= deadline_nxt;
      remaining_r <= remaining_nxt;
      held_r      <= held_nxt;
      active_r    <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_period_r <= RST_POLL_PERIOD;
      half_period_r <= RST_HALF_PERIOD;
      settle_r      <= RST_SETTLE;
      blink_count_r <= RST_BLINK_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLL_PERIOD: poll_period_r <= cfg_wdata;
        REG_HALF_PERIOD: half_period_r <= cfg_wdata;
        REG_SETTLE:      settle_r      <= cfg_wdata;
        REG_BLINK_COUNT: blink_count_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= acc;
      end
    end else if (acc) begin
      if (out_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && skid_valid_r) begin
      out_r <= skid_r;
    end else if (acc && (out_take || !out_valid_r)) begin
      out_r <= res;
    end
    if (acc && out_valid_r && !out_take) begin
      skid_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_write  = out_r.led_write;
  assign out_lamp_color = out_r.lamp_color;
  assign out_send_mask  = out_r.send_mask;
  assign out_send_color = out_r.send_color;

  `LCBI_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r)
  `LCBI_ASSERT_NOW(a_grant_onehot, 1'b1, $onehot0(pick.grant))
  `LCBI_ASSERT_NOW(a_remaining_needs_active, remaining_r != '0, active_r)
  `LCBI_ASSERT_NEXT(a_skid_fills_on_stall, acc && out_valid_r && !out_ready, skid_valid_r)

endmodule

### tb/sv/link_change_blink_indicator_tb.sv
`timescale 1ns / 1ps

module link_change_blink_indicator_tb;
  import lcbi_pkg::*;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int HOLD_CYCLES     = 60;
  localparam int DRAIN_CYCLES    = 8;
  localparam int NUM_REGS        = 5;

  typedef struct {
    logic              op;
    logic [TIME_W-1:0] now;
    logic [CONN_W-1:0] conn;
    logic [7:0]        mtype;
    logic [7:0]        mcolor;
  } link_event_t;

  typedef struct {
    link_event_t ev;
    bit          typed;
    res_t        want;
  } stim_row_t;

  logic              clk                = 1'b0;
  logic              rst_n              = 1'b0;
  logic              in_valid           = 1'b0;
  logic              in_ready;
  logic              in_operation       = OP_POLL;
  logic [TIME_W-1:0] in_now_ms          = '0;
  logic [CONN_W-1:0] in_connected_ports = '0;
  logic [7:0]        in_msg_type        = '0;
  logic [7:0]        in_msg_color       = '0;
  logic              out_valid;
  logic              out_ready          = 1'b0;
  logic              out_led_write;
  logic [1:0]        out_lamp_color;
  logic [CONN_W-1:0] out_send_mask;
  logic [7:0]        out_send_color;
  logic              cfg_we             = 1'b0;
  logic [IDX_W-1:0]  cfg_index          = '0;
  logic [CFG_W-1:0]  cfg_wdata          = '0;

  // predictor copy of configuration and state
  logic [CFG_W-1:0]  poll_gap;
  logic [CFG_W-1:0]  half_gap;
  logic [CFG_W-1:0]  settle_gap;
  logic [CNT_W-1:0]  pair_count;
  logic [PORTS-1:0]  link_up;
  logic [TIME_W-1:0] link_stamp [PORTS];
  logic [TIME_W-1:0] poll_due;
  logic [TIME_W-1:0] flip_due;
  logic [REM_W-1:0]  flips_left;
  logic [7:0]        held_hue;
  logic              blinking;

  res_t led_queue[$];
  int   errors       = 0;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  bit   rx_hold      = 1'b0;

  link_change_blink_indicator u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_now_ms          (in_now_ms),
    .in_connected_ports (in_connected_ports),
    .in_msg_type        (in_msg_type),
    .in_msg_color       (in_msg_color),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_led_write      (out_led_write),
    .out_lamp_color     (out_lamp_color),
    .out_send_mask      (out_send_mask),
    .out_send_color     (out_send_color),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic bit later_than(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && (d < 32'h8000_0000);
  endfunction

  // codes above green light the LED white
  function automatic logic [1:0] lamp_code(input logic [7:0] hue);
    return (hue > COLOR_GREEN) ? COLOR_WHITE[1:0] : hue[1:0];
  endfunction

  task automatic begin_blink(input logic [TIME_W-1:0] now, input logic [CONN_W-1:0] conn,
                             input logic [7:0] hue, output res_t r);
    flips_left      = {pair_count, 1'b0};
    flip_due        = now + TIME_W'(half_gap);
    held_hue        = hue;
    blinking        = 1'b1;
    r.led_write     = 1'b1;
    r.lamp_color    = lamp_code(hue);
    r.send_mask     = conn;
    r.send_color    = hue;
  endtask

  task automatic predict_led(input link_event_t ev, output res_t r);
    logic [7:0] hue;
    r = '0;
    if (ev.op == OP_MSG) begin
      if (ev.mtype == MSG_BLINK_REQUEST && !blinking) begin_blink(ev.now, ev.conn, ev.mcolor, r);
      return;
    end
    if (!later_than(ev.now, poll_due)) return;
    poll_due = ev.now + TIME_W'(poll_gap);
    if (flips_left != '0 && later_than(ev.now, flip_due)) begin
      hue        = flips_left[0] ? held_hue : COLOR_WHITE;
      flips_left = flips_left - 1'b1;
      flip_due   = ev.now + TIME_W'(half_gap);
      if (flips_left == '0) begin
        hue      = COLOR_WHITE;
        blinking = 1'b0;
      end
      r.led_write  = 1'b1;
      r.lamp_color = lamp_code(hue);
      return;
    end
    // lowest-numbered settled port with a new link state wins
    for (int p = 0; p < PORTS; p++) begin
      if (link_up[p] != ev.conn[p] &&
          later_than(ev.now, link_stamp[p] + TIME_W'(settle_gap))) begin
        link_up[p]    = ev.conn[p];
        link_stamp[p] = ev.now;
        begin_blink(ev.now, ev.conn, ev.conn[p] ? COLOR_GREEN : COLOR_RED, r);
        break;
      end
    end
  endtask

  task automatic offer(input link_event_t ev, input bit typed, input res_t want);
    res_t r;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= ev.op;
    in_now_ms          <= ev.now;
    in_connected_ports <= ev.conn;
    in_msg_type        <= ev.mtype;
    in_msg_color       <= ev.mcolor;
    do @(posedge clk); while (!in_ready);
    predict_led(ev, r);
    led_queue.push_back(typed ? want : r);
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_led
    res_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (led_queue.size() == 0) begin
        $display("%0t: result with nothing expected, actual %0d %0d %h %h", $time,
                 out_led_write, out_lamp_color, out_send_mask, out_send_color);
        errors++;
      end else begin
        exp_r = led_queue.pop_front();
        if (out_led_write !== exp_r.led_write) begin
          $display("%0t: led_write expected %0d actual %0d", $time,
                   exp_r.led_write, out_led_write);
          errors++;
        end
        if (out_lamp_color !== exp_r.lamp_color) begin
          $display("%0t: lamp_color expected %0d actual %0d", $time,
                   exp_r.lamp_color, out_lamp_color);
          errors++;
        end
        if (out_send_mask !== exp_r.send_mask) begin
          $display("%0t: send_mask expected %h actual %h", $time,
                   exp_r.send_mask, out_send_mask);
          errors++;
        end
        if (out_send_color !== exp_r.send_color) begin
          $display("%0t: send_color expected %h actual %h", $time,
                   exp_r.send_color, out_send_color);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t         rows[$];
    logic [CFG_W-1:0]  vals [NUM_REGS];
    link_event_t       ev;
    logic [TIME_W-1:0] wall_ms;
    logic [CONN_W-1:0] link_mask;
    res_t              none;
    bit                with_startup;
    int                span;
    int                sent;
    int                roll;
    int                flip;

    none       = '0;
    poll_gap   = RST_POLL_PERIOD;
    half_gap   = RST_HALF_PERIOD;
    settle_gap = RST_SETTLE;
    pair_count = RST_BLINK_COUNT;
    link_up    = '0;
    foreach (link_stamp[p]) link_stamp[p] = '0;
    poll_due   = TIME_W'(RST_STARTUP);
    flip_due   = '0;
    flips_left = '0;
    held_hue   = '0;
    blinking   = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle polls, deadline edge, ignored messages, blink run, wrap of time
    rows.push_back('{'{OP_POLL, 32'd0,          6'h00, 8'h00, 8'h00}, 1'b1, '0});
    rows.push_back('{'{OP_POLL, 32'd1000,       6'h3F, 8'h00, 8'h00}, 1'b1, '0});
    rows.push_back('{'{OP_POLL, 32'h8000_03E8,  6'h3F, 8'h00, 8'h00}, 1'b1, '0});
    rows.push_back('{'{OP_MSG,  32'd5,          6'h3F, 8'h00, 8'h02}, 1'b1, '0});
    rows.push_back('{'{OP_MSG,  32'd6,          6'h3F, 8'hFF, 8'h01}, 1'b1, '0});
    rows.push_back('{'{OP_MSG,  32'd10,         6'h3F, 8'h01, 8'hFF}, 1'b1,
                     res_t'{1'b1, 2'd0, 6'h3F, 8'hFF}});
    rows.push_back('{'{OP_MSG,  32'd11,         6'h3F, 8'h01, 8'h02}, 1'b1, '0});
    rows.push_back('{'{OP_POLL, 32'd1001,       6'h00, 8'h00, 8'h00}, 1'b1,
                     res_t'{1'b1, 2'd0, 6'h00, 8'h00}});
    rows.push_back('{'{OP_POLL, 32'd1401,       6'h00, 8'h00, 8'h00}, 1'b1, '0});
    rows.push_back('{'{OP_POLL, 32'd1402,       6'h00, 8'h00, 8'h00}, 1'b0, '0});
    rows.push_back('{'{OP_POLL, 32'd1803,       6'h00, 8'h00, 8'h00}, 1'b0, '0});
    rows.push_back('{'{OP_POLL, 32'd2204,       6'h00, 8'h00, 8'h00}, 1'b0, '0});
    rows.push_back('{'{OP_POLL, 32'd2605,       6'h00, 8'h00, 8'h00}, 1'b0, '0});
    rows.push_back('{'{OP_POLL, 32'd3006,       6'h00, 8'h00, 8'h00}, 1'b0, '0});
    rows.push_back('{'{OP_POLL, 32'd3407,       6'h01, 8'h00, 8'h00}, 1'b1,
                     res_t'{1'b1, 2'd2, 6'h01, 8'h02}});
    rows.push_back('{'{OP_POLL, 32'd3808,       6'h01, 8'h00, 8'h00}, 1'b0, '0});
    rows.push_back('{'{OP_POLL, 32'h7FFF_0000,  6'h3E, 8'h00, 8'h00}, 1'b0, '0});
    rows.push_back('{'{OP_POLL, 32'hFFFF_0000,  6'h3E, 8'h00, 8'h00}, 1'b0, '0});
    rows.push_back('{'{OP_POLL, 32'hFFFF_FF00,  6'h3E, 8'h00, 8'h00}, 1'b0, '0});
    rows.push_back('{'{OP_POLL, 32'h0000_0100,  6'h3E, 8'h00, 8'h00}, 1'b0, '0});
    rows.push_back('{'{OP_MSG,  32'h0000_0101,  6'h2A, 8'h01, 8'h03}, 1'b0, '0});
    rows.push_back('{'{OP_POLL, 32'h0000_0200,  6'h00, 8'h00, 8'h00}, 1'b0, '0});
    rows.push_back('{'{OP_MSG,  32'hFFFF_FFFF,  6'h15, 8'hFF, 8'hFF}, 1'b0, '0});
    rows.push_back('{'{OP_POLL, 32'h0000_0600,  6'h3F, 8'h00, 8'h00}, 1'b0, '0});

    foreach (rows[i]) offer(rows[i].ev, rows[i].typed, rows[i].want);
    in_valid <= 1'b0;

    wall_ms   = 32'h0000_0600;
    link_mask = 6'h3F;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd1};
        1: vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd15};
        4: vals = '{RST_POLL_PERIOD, RST_STARTUP, RST_HALF_PERIOD, RST_SETTLE,
                    CFG_W'(RST_BLINK_COUNT)};
        default: begin
          foreach (vals[i])
            vals[i] = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom)
                                                  : CFG_W'($urandom_range(0, 1500));
          // a zero count in the last phase locks out blink messages for good
          vals[REG_BLINK_COUNT] = (ph == PHASES - 1) ? '0 : CFG_W'($urandom_range(1, 15));
        end
      endcase
      with_startup = (ph != 2) && (ph != 6);

      // wait for the block to drain before touching registers
      while (led_queue.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      for (int i = 0; i < NUM_REGS; i++) begin
        if (IDX_W'(i) == REG_STARTUP && !with_startup) continue;
        cfg_we    <= 1'b1;
        cfg_index <= IDX_W'(i);
        cfg_wdata <= vals[i];
        case (IDX_W'(i))
          REG_POLL_PERIOD: poll_gap   = vals[i];
          REG_STARTUP:     poll_due   = TIME_W'(vals[i]);
          REG_HALF_PERIOD: half_gap   = vals[i];
          REG_SETTLE:      settle_gap = vals[i];
          REG_BLINK_COUNT: pair_count = vals[i][CNT_W-1:0];
          default: ;
        endcase
        @(posedge clk);
      end
      cfg_we <= 1'b0;

      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
        default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
      endcase
      // hold the output off while the sender keeps pushing
      if (ph == 4) rx_hold = 1'b1;

      span = int'(poll_gap);
      if (int'(half_gap) > span) span = int'(half_gap);
      if (int'(settle_gap >> 2) > span) span = int'(settle_gap >> 2);
      span = span + 1;

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          flip = $urandom_range(0, CONN_W - 1);
          link_mask[flip] = ~link_mask[flip];
        end else if (roll < 13) begin
          link_mask = CONN_W'($urandom);
        end
        ev.conn = link_mask;
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          // noise: a non-blink message with arbitrary time and payload
          ev.op   = OP_MSG;
          ev.now  = $urandom;
          ev.conn = CONN_W'($urandom);
          do ev.mtype = 8'($urandom); while (ev.mtype == MSG_BLINK_REQUEST);
          ev.mcolor = 8'($urandom);
        end else begin
          wall_ms = wall_ms + $urandom_range(0, span);
          ev.now  = wall_ms;
          if (roll < 10) ev.now = wall_ms - $urandom_range(0, span);
          else if (roll < 14) ev.now = poll_due + $urandom_range(0, 1);
          ev.op = (roll < 78) ? OP_POLL : OP_MSG;
          if (ev.op == OP_MSG) begin
            ev.mtype  = ($urandom_range(0, 3) != 0) ? MSG_BLINK_REQUEST : 8'($urandom);
            ev.mcolor = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
          end else begin
            ev.mtype  = 8'($urandom);
            ev.mcolor = 8'($urandom);
          end
          sent++;
        end
        offer(ev, 1'b0, none);
      end
      in_valid <= 1'b0;
    end

    while (led_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### link_change_blink_indicator.f
+incdir+rtl/core
rtl/core/lcbi_pkg.sv
rtl/core/lcbi_port_lane.sv
rtl/core/lcbi_merge.sv
rtl/core/link_change_blink_indicator.sv
tb/sv/link_change_blink_indicator_tb.sv
